>>> rtl/core/lpim_pkg.sv
// Shared types and constants for the linear-probe id map.
// No dependencies; imported by every module of the block.
`default_nettype none
package lpim_pkg;
  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 16;
  localparam int HANDLE_W = 8;
  localparam int LOAD_LIMIT = SLOTS * 3 / 4;
  localparam int HALF_SLOTS = SLOTS / 2;

  typedef enum logic [1:0] {MARK_EMPTY = 2'd0, MARK_LIVE = 2'd1, MARK_TOMB = 2'd2}
    mark_t;
  typedef enum logic [1:0] {OP_PUT = 2'd0, OP_GET = 2'd1, OP_DEL = 2'd2, OP_NOP = 2'd3}
    op_t;
  typedef enum logic [1:0] {STAT_OK = 2'd0, STAT_MISS = 2'd1, STAT_FULL = 2'd2}
    status_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_RB_RD, ST_RB_CHK, ST_RB_PLACE
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_bus_t;

  typedef struct packed {
    mark_t               mark;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
  } result_t;
endpackage
`default_nettype wire

>>> rtl/core/lpim_front.sv
// Front end: decodes the op kind and queues commands, two deep.
// Depends on lpim_pkg.
`default_nettype none
module lpim_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [1:0]                       kind,
  input  wire logic [lpim_pkg::KEY_W-1:0]       stream_id,
  input  wire logic [lpim_pkg::HANDLE_W-1:0]    handle,
  output lpim_pkg::cmd_bus_t                    cmd_bus,
  input  wire logic                             cmd_pop
);
  import lpim_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  always_comb begin
    case (kind)
      2'd0: cmd_in.op = OP_PUT;
      2'd1: cmd_in.op = OP_GET;
      2'd2: cmd_in.op = OP_DEL;
      default: cmd_in.op = OP_NOP;
    endcase
    cmd_in.key = stream_id;
    cmd_in.handle = handle;
  end

  assign full = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop = cmd_pop && (count != 2'd0);
  assign cmd_bus.valid = (count != 2'd0);
  assign cmd_bus.cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/lpim_back.sv
// Back end: probe sequencer over a two-bank slot memory, rebuild sweep, result queue.
// Depends on lpim_pkg.
`default_nettype none
module lpim_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lpim_pkg::cmd_bus_t            cmd_bus,
  output logic                               cmd_pop,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [1:0]                         status,
  output logic [lpim_pkg::HANDLE_W-1:0]      found_handle
);
  import lpim_pkg::*;

  // slot memory: bank in the top address bit; per-entry valid flops stand in for reset
  entry_t     mem [2*SLOTS];
  logic       vld [2][SLOTS];
  entry_t     rdata;
  logic       rvld;

  state_t              state, state_next;
  cmd_t                cur, cur_next;
  logic                bank, bank_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    n, n_next;
  logic [IDX_W-1:0]    scan, scan_next;
  logic [CNT_W-1:0]    live, live_next;
  logic [CNT_W-1:0]    tomb, tomb_next;

  logic                rd_en;
  logic [IDX_W:0]      raddr;
  logic                we;
  logic [IDX_W:0]      waddr;
  entry_t              wdata;
  logic                clr_bank;
  logic                res_push;
  result_t             res_in;

  result_t    rq [2];
  logic       rq_wr, rq_rd;
  logic [1:0] rq_cnt;
  logic       res_pop;

  mark_t               cur_mark;
  logic [CNT_W:0]      load_sum;

  assign cur_mark = rvld ? rdata.mark : MARK_EMPTY;
  assign load_sum = {1'b0, live} + {1'b0, tomb} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    state_next = state;
    cur_next = cur;
    bank_next = bank;
    idx_next = idx;
    n_next = n;
    scan_next = scan;
    live_next = live;
    tomb_next = tomb;
    cmd_pop = 1'b0;
    rd_en = 1'b0;
    raddr = {bank, idx};
    we = 1'b0;
    waddr = {bank, idx};
    wdata = '{mark: MARK_LIVE, key: cur.key, handle: cur.handle};
    clr_bank = 1'b0;
    res_push = 1'b0;
    res_in = '{status: STAT_MISS, handle: '0};
    case (state)
      ST_IDLE: begin
        if (cmd_bus.valid && rq_cnt != 2'd2) begin
          cmd_pop = 1'b1;
          cur_next = cmd_bus.cmd;
          idx_next = cmd_bus.cmd.key[IDX_W-1:0];
          n_next = '0;
          scan_next = '0;
          case (cmd_bus.cmd.op)
            OP_PUT: begin
              if (load_sum >= (CNT_W+1)'(LOAD_LIMIT)) begin
                if (live < CNT_W'(HALF_SLOTS)) begin
                  clr_bank = 1'b1;
                  state_next = ST_RB_RD;
                end else begin
                  res_push = 1'b1;
                  res_in.status = STAT_FULL;
                end
              end else begin
                state_next = ST_RD;
              end
            end
            OP_GET, OP_DEL: state_next = ST_RD;
            default: res_push = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (cur.op == OP_PUT) begin
          if (cur_mark != MARK_LIVE) begin
            we = 1'b1;
            if (cur_mark == MARK_TOMB && tomb != '0) tomb_next = tomb - 1'b1;
            live_next = live + 1'b1;
            res_push = 1'b1;
            res_in.status = STAT_OK;
            state_next = ST_IDLE;
          end else if (n == '1) begin
            res_push = 1'b1;
            res_in.status = STAT_FULL;
            state_next = ST_IDLE;
          end else begin
            n_next = n + 1'b1;
            idx_next = idx + 1'b1;
            state_next = ST_RD;
          end
        end else begin
          if (cur_mark == MARK_EMPTY) begin
            res_push = 1'b1;
            state_next = ST_IDLE;
          end else if (cur_mark == MARK_LIVE && rdata.key == cur.key) begin
            res_push = 1'b1;
            res_in.status = STAT_OK;
            if (cur.op == OP_GET) begin
              res_in.handle = rdata.handle;
            end else begin
              we = 1'b1;
              wdata = '{mark: MARK_TOMB, key: rdata.key, handle: rdata.handle};
              if (live != '0) live_next = live - 1'b1;
              tomb_next = tomb + 1'b1;
            end
            state_next = ST_IDLE;
          end else if (n == '1) begin
            res_push = 1'b1;
            state_next = ST_IDLE;
          end else begin
            n_next = n + 1'b1;
            idx_next = idx + 1'b1;
            state_next = ST_RD;
          end
        end
      end
      ST_RB_RD: begin
        rd_en = 1'b1;
        raddr = {bank, scan};
        state_next = ST_RB_CHK;
      end
      ST_RB_CHK: begin
        // live entry: probe the new bank from its home slot
        if (cur_mark == MARK_LIVE) begin
          n_next = rdata.key[IDX_W-1:0];
          state_next = ST_RB_PLACE;
        end else if (scan == '1) begin
          bank_next = ~bank;
          tomb_next = '0;
          n_next = '0;
          state_next = ST_RD;
        end else begin
          scan_next = scan + 1'b1;
          state_next = ST_RB_RD;
        end
      end
      ST_RB_PLACE: begin
        // rdata still holds the entry being moved; new bank has no tombstones
        if (!vld[~bank][n]) begin
          we = 1'b1;
          waddr = {~bank, n};
          wdata = rdata;
          if (scan == '1) begin
            bank_next = ~bank;
            tomb_next = '0;
            n_next = '0;
            state_next = ST_RD;
          end else begin
            scan_next = scan + 1'b1;
            state_next = ST_RB_RD;
          end
        end else begin
          n_next = n + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rdata <= mem[raddr];
      rvld <= vld[raddr[IDX_W]][raddr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < SLOTS; i++) vld[b][i] <= 1'b0;
      end
    end else begin
      if (clr_bank) begin
        for (int i = 0; i < SLOTS; i++) vld[~bank][i] <= 1'b0;
      end
      if (we) vld[waddr[IDX_W]][waddr[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    n <= n_next;
    scan <= scan_next;
    if (rst) begin
      state <= ST_IDLE;
      bank <= 1'b0;
      live <= '0;
      tomb <= '0;
    end else begin
      state <= state_next;
      bank <= bank_next;
      live <= live_next;
      tomb <= tomb_next;
    end
  end

  // result queue, two beats deep
  assign empty = (rq_cnt == 2'd0);
  assign res_pop = pop && !empty;
  assign status = rq[rq_rd].status;
  assign found_handle = rq[rq_rd].handle;

  always_ff @(posedge clk) begin
    if (res_push) rq[rq_wr] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr <= 1'b0;
      rq_rd <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (res_push) rq_wr <= ~rq_wr;
      if (res_pop) rq_rd <= ~rq_rd;
      rq_cnt <= rq_cnt + {1'b0, res_push} - {1'b0, res_pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/linear_probe_id_map.sv
// Top level of the linear-probe id map: front command queue and back probe engine.
// Depends on lpim_pkg, lpim_front, lpim_back.
`default_nettype none
// Open-addressing map from a 16-bit stream id to an 8-bit handle, 64 slots, linear
// probing with tombstones; one result beat per op, in order. Both sides are queues
// (push/full in, empty/pop out), each two beats deep. Ops run one at a time in the
// back engine; each op is dispatched from idle, then each probed slot is a registered
// memory read followed by a check (kind 3 and a refused insert end at dispatch). An
// insert at three-quarters load with under half live triggers a rebuild into the
// other bank: each old slot is read and checked, and each live entry is placed in the
// new bank by stepping on from its home slot to the first free slot.
module linear_probe_id_map (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    kind,
  input  wire logic [lpim_pkg::KEY_W-1:0]    stream_id,
  input  wire logic [lpim_pkg::HANDLE_W-1:0] handle,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [1:0]                         status,
  output logic [lpim_pkg::HANDLE_W-1:0]      found_handle
);
  import lpim_pkg::*;

  cmd_bus_t cmd_bus;
  logic     cmd_pop;

  lpim_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .stream_id(stream_id), .handle(handle), .cmd_bus(cmd_bus), .cmd_pop(cmd_pop)
  );

  lpim_back u_back (
    .clk(clk), .rst(rst), .cmd_bus(cmd_bus), .cmd_pop(cmd_pop), .empty(empty),
    .pop(pop), .status(status), .found_handle(found_handle)
  );
endmodule
`default_nettype wire
